[src/assert_macros.svh]
// Assertion macros shared by the key slot allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

[src/ksa_pkg.sv]
// Types and constants of the key slot allocator table.
`default_nettype none

package ksa_pkg;

   localparam int KIND_W   = 2;
   localparam int KEY_W    = 10;
   localparam int VAL_W    = 64;
   localparam int STATUS_W = 2;

   // Number of slots that the key field can name.
   localparam int KEY_SPAN = 1024;

   // The in-use marks are stored in rows of this many bits.
   localparam int ROW_BITS  = 32;
   localparam int ROW_SHIFT = 5;

   typedef enum logic [KIND_W-1:0] {
      OP_CREATE = 2'd0,
      OP_SET    = 2'd1,
      OP_GET    = 2'd2,
      OP_DELETE = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BADKEY = 2'd2
   } status_type;

   typedef enum logic {
      CS_IDLE = 1'b0,
      CS_EXEC = 1'b1
   } ctl_state_type;

   typedef struct packed {
      logic accept;
      logic commit;
   } ctl_cmd_type;

endpackage

`default_nettype wire

[src/ksa_ifs.sv]
// Request and response channel interfaces of the key slot allocator table.
`default_nettype none

interface ksa_req_if import ksa_pkg::*;;
   logic             valid;
   logic             ready;
   logic [KIND_W-1:0] kind;
   logic [KEY_W-1:0]  key;
   logic [VAL_W-1:0]  value;

   modport source (output valid, output kind, output key, output value, input ready);
   modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface ksa_rsp_if import ksa_pkg::*;;
   logic               valid;
   logic               ready;
   logic [STATUS_W-1:0] status;
   logic [KEY_W-1:0]    new_key;
   logic [VAL_W-1:0]    read_value;

   modport source (output valid, output status, output new_key, output read_value,
                   input ready);
   modport sink   (input valid, input status, input new_key, input read_value,
                   output ready);
endinterface

`default_nettype wire

[src/ksa_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module ksa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [ADDR_W-1:0]        waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [ADDR_W-1:0]        raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[src/ksa_ctrl.sv]
// Controller state machine of the key slot allocator table.
`default_nettype none

`include "assert_macros.svh"

module ksa_ctrl import ksa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output ctl_cmd_type      cmd
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = CS_EXEC;
            end
         end
         CS_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit | (rsp_valid_ff & ~rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_CLK(a_accept_then_exec, cmd.accept |=> (state_ff == CS_EXEC), "accept did not start execution")
   `ASSERT_CLK(a_commit_shows_rsp, cmd.commit |=> rsp_valid_ff, "committed request has no response")
   `ASSERT_NEVER(a_rsp_overwrite, cmd.commit && rsp_valid_ff && !rsp_ready, "pending response overwritten")

endmodule

`default_nettype wire

[src/ksa_dpath.sv]
// Datapath of the key slot allocator table: in-use rows, value store and response register.
`default_nettype none

`include "assert_macros.svh"

module ksa_dpath import ksa_pkg::*; #(
   parameter int KEY_SLOTS  = 1024,
   parameter int VALUE_BITS = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ctl_cmd_type         cmd,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic [KEY_W-1:0]    req_key,
   input  wire logic [VAL_W-1:0]    req_value,
   output logic      [STATUS_W-1:0] rsp_status,
   output logic      [KEY_W-1:0]    rsp_new_key,
   output logic      [VAL_W-1:0]    rsp_read_value
);

   localparam int LIVE    = (KEY_SLOTS < KEY_SPAN) ? KEY_SLOTS : KEY_SPAN;
   localparam int ROW_CNT = (LIVE + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_AW  = (ROW_CNT > 1) ? $clog2(ROW_CNT) : 1;
   localparam int SLOT_AW = $clog2(LIVE);

   op_type                kind_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [ROW_AW-1:0]     row_ff;
   logic                  full_ff;
   logic                  range_ok_ff;
   logic [ROW_CNT-1:0]    row_valid_ff;
   logic [ROW_CNT-1:0]    row_full_ff;

   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]      rsp_new_key_ff, rsp_new_key_in;
   logic [VAL_W-1:0]      rsp_read_value_ff, rsp_read_value_in;

   logic [ROW_AW-1:0]     free_row;
   logic                  any_free;
   logic [ROW_AW-1:0]     key_row;
   logic [ROW_AW-1:0]     used_raddr;
   logic [SLOT_AW-1:0]    val_raddr;

   logic [ROW_BITS-1:0]   used_q;
   logic [VALUE_BITS-1:0] val_q;
   logic [ROW_BITS-1:0]   row_word;
   logic [ROW_BITS-1:0]   pad;
   logic [ROW_BITS-1:0]   fill;
   logic [ROW_SHIFT-1:0]  bit_idx;
   logic [ROW_SHIFT-1:0]  free_bit;
   logic [15:0]           slot_wide;
   logic                  live;

   logic                  used_we;
   logic [ROW_BITS-1:0]   used_wdata;
   logic                  val_we;
   logic [SLOT_AW-1:0]    val_waddr;
   logic [VALUE_BITS-1:0] val_wdata;

   // Lowest row that still holds a free slot.
   always_comb begin
      free_row = '0;
      any_free = 1'b0;
      for (int i = ROW_CNT - 1; i >= 0; i--) begin
         if (!row_full_ff[i]) begin
            free_row = ROW_AW'(i);
            any_free = 1'b1;
         end
      end
   end

   assign key_row    = ROW_AW'(req_key >> ROW_SHIFT);
   assign used_raddr = (op_type'(req_kind) == OP_CREATE) ? free_row : key_row;
   assign val_raddr  = SLOT_AW'(req_key);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff     <= op_type'(req_kind);
         key_ff      <= req_key;
         value_ff    <= VALUE_BITS'(req_value);
         row_ff      <= used_raddr;
         full_ff     <= !any_free;
         range_ok_ff <= (int'(req_key) < LIVE);
      end
   end

   ksa_ram #(.WIDTH(ROW_BITS), .DEPTH(ROW_CNT)) u_used_ram (
      .clock (clock),
      .we    (used_we),
      .waddr (row_ff),
      .wdata (used_wdata),
      .re    (cmd.accept),
      .raddr (used_raddr),
      .rdata (used_q)
   );

   ksa_ram #(.WIDTH(VALUE_BITS), .DEPTH(LIVE)) u_value_ram (
      .clock (clock),
      .we    (val_we),
      .waddr (val_waddr),
      .wdata (val_wdata),
      .re    (cmd.accept),
      .raddr (val_raddr),
      .rdata (val_q)
   );

   // A row that was never written holds only free slots.
   always_comb begin
      row_word = row_valid_ff[row_ff] ? used_q : '0;
      for (int b = 0; b < ROW_BITS; b++) begin
         pad[b] = ((int'(row_ff) << ROW_SHIFT) + b) >= LIVE;
      end
      fill     = row_word | pad;
      free_bit = '0;
      for (int b = ROW_BITS - 1; b >= 0; b--) begin
         if (!fill[b]) begin
            free_bit = ROW_SHIFT'(b);
         end
      end
      slot_wide = (16'(row_ff) << ROW_SHIFT) | 16'(free_bit);
      bit_idx   = key_ff[ROW_SHIFT-1:0];
      live      = range_ok_ff && row_word[bit_idx];
   end

   always_comb begin
      rsp_status_in     = ST_OK;
      rsp_new_key_in    = '0;
      rsp_read_value_in = '0;
      used_we           = 1'b0;
      used_wdata        = row_word;
      val_we            = 1'b0;
      val_waddr         = SLOT_AW'(key_ff);
      val_wdata         = value_ff;
      case (kind_ff)
         OP_CREATE: begin
            if (full_ff) begin
               rsp_status_in = ST_FULL;
            end else begin
               rsp_new_key_in = KEY_W'(slot_wide);
               used_we        = cmd.commit;
               used_wdata     = row_word | (ROW_BITS'(1) << free_bit);
               val_we         = cmd.commit;
               val_waddr      = SLOT_AW'(slot_wide);
               val_wdata      = '0;
            end
         end
         OP_SET: begin
            if (live) begin
               val_we = cmd.commit;
            end else begin
               rsp_status_in = ST_BADKEY;
            end
         end
         OP_GET: begin
            if (live) begin
               rsp_read_value_in = VAL_W'(val_q);
            end else begin
               rsp_status_in = ST_BADKEY;
            end
         end
         OP_DELETE: begin
            if (live) begin
               used_we    = cmd.commit;
               used_wdata = row_word & ~(ROW_BITS'(1) << bit_idx);
            end else begin
               rsp_status_in = ST_BADKEY;
            end
         end
         default: begin
            rsp_status_in = ST_BADKEY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         row_full_ff  <= '0;
      end else if (used_we) begin
         row_valid_ff[row_ff] <= 1'b1;
         row_full_ff[row_ff]  <= &(used_wdata | pad);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff     <= rsp_status_in;
         rsp_new_key_ff    <= rsp_new_key_in;
         rsp_read_value_ff <= rsp_read_value_in;
      end
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_new_key    = rsp_new_key_ff;
   assign rsp_read_value = rsp_read_value_ff;

   `ASSERT_CLK(a_create_slot_free, (cmd.commit && kind_ff == OP_CREATE && !full_ff) |-> (slot_wide < LIVE && !fill[free_bit]), "create picked a slot that is not free")
   `ASSERT_CLK(a_delete_frees_row, (cmd.commit && kind_ff == OP_DELETE && live) |=> !row_full_ff[$past(row_ff)], "row still full after delete")

endmodule

`default_nettype wire

[src/key_slot_allocator_table.sv]
// Top level of the key slot allocator table.
`default_nettype none

// In the accept cycle of a request the in-use row and the value entry are read from
// their RAMs, and in the execute cycle the registered read data decides the result,
// the RAMs are updated and the response register is loaded. The execute cycle waits
// while an earlier response is still held in the response register. Create finds the
// lowest free slot through a full flag per row of 32 slots and a priority encoder
// within the row. After reset every slot is free at once: each row has a valid flag
// that reset clears, so there is no clearing pass.
module key_slot_allocator_table import ksa_pkg::*; #(
   parameter int KEY_SLOTS  = 1024,
   parameter int VALUE_BITS = 64
) (
   input wire logic clock,
   input wire logic reset,
   ksa_req_if.sink  req_bus,
   ksa_rsp_if.source rsp_bus
);

   ctl_cmd_type cmd;

   ksa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   ksa_dpath #(.KEY_SLOTS(KEY_SLOTS), .VALUE_BITS(VALUE_BITS)) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_kind       (req_bus.kind),
      .req_key        (req_bus.key),
      .req_value      (req_bus.value),
      .rsp_status     (rsp_bus.status),
      .rsp_new_key    (rsp_bus.new_key),
      .rsp_read_value (rsp_bus.read_value)
   );

endmodule

`default_nettype wire
